FILE: rtl/shv_pkg.sv
// Shared types, tail codes and round functions for the streaming message hash.
// No dependencies; used by shv_front, shv_back and the top level.
package shv_pkg;

  localparam int HashWidth = 32;
  localparam int LenWidth  = 13;

  // Valid bytes in a last word (length mod 4); zero means a full word.
  localparam logic [1:0] TAIL_FULL = 2'd0;
  localparam logic [1:0] TAIL_ONE  = 2'd1;
  localparam logic [1:0] TAIL_TWO  = 2'd2;
  localparam logic [1:0] TAIL_THREE = 2'd3;

  // Front to back: round result of a last word.
  typedef struct packed {
    logic [HashWidth-1:0] hash;
    logic                 len_zero;
  } mid_entry_t;

  // Back to front: a finished hash has just been produced.
  typedef struct packed {
    logic                 done;
    logic [HashWidth-1:0] final_hash;
  } back_status_t;

  function automatic logic [31:0] asr11(input logic [31:0] x);
    asr11 = $unsigned($signed(x) >>> 11);
  endfunction

  function automatic logic [31:0] word_round(input logic [31:0] c_in,
                                             input logic [31:0] w,
                                             input logic [1:0]  tail);
    logic [31:0] c;
    logic [31:0] t;
    logic [31:0] lo16;
    logic [31:0] hi16;
    logic [31:0] b0;
    logic [31:0] b2;
    lo16 = {{16{w[15]}}, w[15:0]};
    hi16 = {{16{w[31]}}, w[31:16]};
    b0   = {{24{w[7]}}, w[7:0]};
    b2   = {{24{w[23]}}, w[23:16]};
    case (tail)
      TAIL_THREE: begin
        c = c_in + lo16;
        t = (b2 << 2) ^ c;
        c = c ^ (t << 16);
        c = c + asr11(c);
      end
      TAIL_TWO: begin
        c = c_in + lo16;
        c = c ^ (c << 11);
        c = c + $unsigned($signed(c) >>> 17);
      end
      TAIL_ONE: begin
        c = c_in + b0;
        c = c ^ (c << 10);
        c = c + $unsigned($signed(c) >>> 1);
      end
      default: begin
        c = c_in + lo16;
        t = hi16 ^ (c << 5);
        t = t << 11;
        c = c ^ t;
        c = c + asr11(c);
      end
    endcase
    word_round = c;
  endfunction

  function automatic logic [31:0] aval_a(input logic [31:0] x);
    logic [31:0] c;
    c = x ^ (x << 3);
    aval_a = c + $unsigned($signed(c) >>> 5);
  endfunction

  function automatic logic [31:0] aval_b(input logic [31:0] x);
    logic [31:0] c;
    c = x ^ (x << 4);
    aval_b = c + $unsigned($signed(c) >>> 17);
  endfunction

  function automatic logic [31:0] aval_c(input logic [31:0] x);
    logic [31:0] c;
    c = x ^ (x << 25);
    aval_c = c + $unsigned($signed(c) >>> 6);
  endfunction

endpackage

FILE: rtl/message_hash_superfast_variant.sv
// Top level of the streaming SuperFastHash-style message hash.
// Depends on shv_pkg, shv_fifo, shv_front and shv_back.
//
// Channel   Direction  Handshake          Item
// input     in         push / full        data_word, first_word, last_word,
//                                         message_length
// result    out        empty / pop        hash_value (one per last word)
//
// One word per cycle while full is low. The word round (add, shift/XOR, add)
// is combinational on the front register, against the running hash. Last words
// go through a queue into a three-stage avalanche pipe and a result queue; a
// hash is registered in each of them before it reaches the result ports.
// Reset (rst, synchronous) clears the running hash, length and all queues.
// full rises when a word that continues after a last word (no first flag)
// must wait for that hash to leave the pipe, or when the middle queue is
// full; a stalled result queue backs up through the pipe credit to full.
module message_hash_superfast_variant
  import shv_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [12:0] message_length,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value
);

  mid_entry_t   mid_in;
  mid_entry_t   mid_out;
  logic         mid_push;
  logic         mid_pop;
  logic         mid_full;
  logic         mid_empty;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  back_status_t back_status;

  // Front: input register and word round.
  shv_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_word      (data_word),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .mid_push       (mid_push),
    .mid_entry      (mid_in),
    .mid_full       (mid_full),
    .back_status    (back_status)
  );

  // Decouples the round from the avalanche pipe.
  shv_fifo #(
    .WIDTH ($bits(mid_entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  // Back: avalanche and result queue.
  shv_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mid_entry   (mid_out),
    .mid_empty   (mid_empty),
    .mid_pop     (mid_pop),
    .back_status (back_status),
    .pop         (pop),
    .empty       (empty),
    .hash_value  (hash_value)
  );

`ifndef SYNTHESIS
  a_mid_count: assert property (@(posedge clk) disable iff (rst)
    mid_full |-> (mid_count != '0))
    else $error("middle queue flags disagree");

  a_mid_flags: assert property (@(posedge clk) disable iff (rst)
    !(mid_full && mid_empty))
    else $error("middle queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("avalanche took from an empty queue");
`endif

endmodule

FILE: rtl/shv_fifo.sv
// Small register queue with show-ahead head, used between and after stages.
// No dependencies.
module shv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CntW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/shv_front.sv
// Front part: takes input items, runs the per-word round, passes last words on.
// Depends on shv_pkg.
module shv_front
  import shv_pkg::*;
#(
  parameter int MID_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [31:0]          data_word,
  input  logic                 first_word,
  input  logic                 last_word,
  input  logic [12:0]          message_length,
  output logic                 mid_push,
  output mid_entry_t           mid_entry,
  input  logic                 mid_full,
  input  back_status_t         back_status
);

  // Up to MID_DEPTH queued plus three in the avalanche pipe.
  localparam int OutstW = $clog2(MID_DEPTH + 4);

  logic              in_valid;
  logic [31:0]       in_data;
  logic              in_first;
  logic              in_last;
  logic [12:0]       in_len;

  logic [31:0]       running_hash;
  logic [12:0]       latched_length;
  logic              prev_last;
  logic [OutstW-1:0] outstanding;

  logic              accept;
  logic              advance;
  logic [12:0]       len_eff;
  logic [31:0]       c_in;
  logic [31:0]       c_round;
  logic [1:0]        tail;

  // A word continuing after a last word needs that message's finished hash.
  assign advance = in_valid
                && (in_first || !prev_last || outstanding == '0)
                && (!in_last || !mid_full);
  assign full    = in_valid && !advance;
  assign accept  = push && !full;

  assign len_eff = in_first ? in_len : latched_length;
  assign c_in    = in_first ? {19'd0, in_len}
                 : (prev_last ? back_status.final_hash : running_hash);
  assign tail    = in_last ? len_eff[1:0] : TAIL_FULL;
  assign c_round = word_round(c_in, in_data, tail);

  assign mid_push           = advance && in_last;
  assign mid_entry.hash     = c_round;
  assign mid_entry.len_zero = (len_eff == '0);

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data  <= data_word;
      in_first <= first_word;
      in_last  <= last_word;
      in_len   <= message_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      running_hash   <= '0;
      latched_length <= '0;
      prev_last      <= 1'b0;
      outstanding    <= '0;
    end else begin
      in_valid <= accept || (in_valid && !advance);
      if (advance) begin
        latched_length <= len_eff;
        prev_last      <= in_last;
        if (!in_last) begin
          running_hash <= c_round;
        end
      end
      if (mid_push && !back_status.done) begin
        outstanding <= outstanding + 1'b1;
      end else if (!mid_push && back_status.done) begin
        outstanding <= outstanding - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_mid_room: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("last word pushed into a full queue");

  a_wait_final: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_first && prev_last) |-> (outstanding == '0))
    else $error("continued from an unfinished hash");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (outstanding == '0) |-> !(back_status.done && !mid_push))
    else $error("hash finished with none outstanding");
`endif

endmodule

FILE: rtl/shv_back.sv
// Back part: avalanche pipeline over queued last words, then the result queue.
// Depends on shv_pkg and shv_fifo.
module shv_back
  import shv_pkg::*;
#(
  parameter int OUT_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mid_entry_t           mid_entry,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  output back_status_t         back_status,
  input  logic                 pop,
  output logic                 empty,
  output logic [31:0]          hash_value
);

  localparam int CntW = $clog2(OUT_DEPTH + 1);

  logic              v1;
  logic              v2;
  logic              v3;
  logic [31:0]       d1;
  logic [31:0]       d2;
  logic [31:0]       d3;
  logic              z1;
  logic              z2;
  logic              out_full;
  logic [CntW-1:0]   out_count;
  logic [CntW+1:0]   committed;

  // Only start an item if the result queue has room for all in flight.
  assign committed = (CntW+2)'(out_count) + (CntW+2)'(v1) + (CntW+2)'(v2) + (CntW+2)'(v3);
  assign mid_pop   = !mid_empty && (committed < (CntW+2)'(OUT_DEPTH));

  assign back_status.done       = v3;
  assign back_status.final_hash = d3;

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      d1 <= aval_a(mid_entry.hash);
      z1 <= mid_entry.len_zero;
    end
    if (v1) begin
      d2 <= aval_b(d1);
      z2 <= z1;
    end
    if (v2) begin
      d3 <= z2 ? '0 : aval_c(d2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= mid_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  shv_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (v3),
    .wdata (d3),
    .pop   (pop),
    .rdata (hash_value),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

`ifndef SYNTHESIS
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    v3 |-> !out_full)
    else $error("result dropped at full queue");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    committed <= (CntW+2)'(OUT_DEPTH))
    else $error("more results in flight than queue room");

  a_pipe: assert property (@(posedge clk) disable iff (rst)
    mid_pop |=> v1 ##1 v2 ##1 v3)
    else $error("avalanche pipe lost an item");
`endif

endmodule
